// File: rtl/core/ffr_pkg.sv
// Package for the framed file receiver: result record, phase and kind codes,
// frame constants and result queue sizing. No dependencies.
package ffr_pkg;

  localparam logic [31:0] SYNC_WORD  = 32'h4649_534B;
  localparam logic [7:0]  PAD_CHAR   = 8'h20;
  localparam logic [7:0]  DOT_CHAR   = 8'h2E;
  localparam int unsigned LEN_BYTES  = 4;
  localparam int unsigned BASE_BYTES = 8;
  localparam int unsigned NAME_BYTES = 11;

  // Result queue: two free entries are needed before a byte may be processed.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_NAME = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_NAME_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [31:0] offset;
    logic        last_of_run;
    logic        end_of_frame;
  } res_t;

  // Results caused by one byte, up to two, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    res_t       r1;
    res_t       r0;
  } res_grp_t;

endpackage

// File: rtl/core/ffr_frame_ctrl.sv
// Frame parser: sync hunt, length, name formatting and payload numbering.
// Holds the frame state; depends on ffr_pkg.
module ffr_frame_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  output ffr_pkg::res_grp_t res_o
);
  import ffr_pkg::*;

  logic [31:0] sync_shift_q, sync_shift_d;
  phase_e      phase_q, phase_d;
  logic [31:0] field_count_q, field_count_d;
  logic [31:0] payload_length_q, payload_length_d;
  logic        base_stopped_q, base_stopped_d;
  logic        ext_stopped_q, ext_stopped_d;
  logic [3:0]  name_out_pos_q, name_out_pos_d;

  res_t        r0, r1;
  logic [1:0]  n;
  logic        in_base;
  logic        stopped;
  logic [32:0] fc_p1;

  assign in_base = field_count_q < 32'(BASE_BYTES);
  assign stopped = in_base ? base_stopped_q : ext_stopped_q;
  assign fc_p1   = {1'b0, field_count_q} + 33'd1;

  always_comb begin
    sync_shift_d     = sync_shift_q;
    phase_d          = phase_q;
    field_count_d    = field_count_q;
    payload_length_d = payload_length_q;
    base_stopped_d   = base_stopped_q;
    ext_stopped_d    = ext_stopped_q;
    name_out_pos_d   = name_out_pos_q;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;

    unique case (phase_q)
      PH_HUNT: begin
        sync_shift_d = {sync_shift_q[23:0], byte_i};
        if ({sync_shift_q[23:0], byte_i} == SYNC_WORD) begin
          phase_d          = PH_LEN;
          field_count_d    = '0;
          payload_length_d = '0;
        end
      end
      PH_LEN: begin
        payload_length_d = {payload_length_q[23:0], byte_i};
        field_count_d    = fc_p1[31:0];
        if (fc_p1 >= 33'(LEN_BYTES)) begin
          phase_d        = PH_NAME;
          field_count_d  = '0;
          base_stopped_d = 1'b0;
          ext_stopped_d  = 1'b0;
          name_out_pos_d = '0;
        end
      end
      PH_NAME: begin
        if (!stopped) begin
          if (byte_i == PAD_CHAR) begin
            if (in_base) base_stopped_d = 1'b1;
            else         ext_stopped_d  = 1'b1;
          end else begin
            r0.kind        = KIND_CHAR;
            r0.data        = byte_i;
            r0.offset      = {28'd0, name_out_pos_d};
            n              = 2'd1;
            name_out_pos_d = name_out_pos_d + 4'd1;
          end
        end
        // The last base byte is always followed by the dot.
        if (field_count_q == 32'(BASE_BYTES - 1)) begin
          if (n == 2'd0) begin
            r0.kind   = KIND_CHAR;
            r0.data   = DOT_CHAR;
            r0.offset = {28'd0, name_out_pos_d};
          end else begin
            r1.kind   = KIND_CHAR;
            r1.data   = DOT_CHAR;
            r1.offset = {28'd0, name_out_pos_d};
          end
          n              = n + 2'd1;
          name_out_pos_d = name_out_pos_d + 4'd1;
        end
        if (field_count_q >= 32'(NAME_BYTES - 1)) begin
          if (n == 2'd0) begin
            r0.kind         = KIND_NAME_DONE;
            r0.data         = {4'd0, name_out_pos_d};
            r0.end_of_frame = payload_length_q == '0;
          end else begin
            r1.kind         = KIND_NAME_DONE;
            r1.data         = {4'd0, name_out_pos_d};
            r1.end_of_frame = payload_length_q == '0;
          end
          n             = n + 2'd1;
          field_count_d = '0;
          if (payload_length_q == '0) begin
            sync_shift_d = '0;
            phase_d      = PH_HUNT;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          field_count_d = fc_p1[31:0];
        end
      end
      PH_DATA: begin
        r0.kind   = KIND_PAYLOAD;
        r0.data   = byte_i;
        r0.offset = field_count_q;
        n         = 2'd1;
        if (fc_p1 == {1'b0, payload_length_q}) begin
          r0.end_of_frame = 1'b1;
          sync_shift_d    = '0;
          phase_d         = PH_HUNT;
          field_count_d   = '0;
        end else begin
          field_count_d = fc_p1[31:0];
        end
      end
    endcase

    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign res_o.count = n;
  assign res_o.r0    = r0;
  assign res_o.r1    = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_shift_q     <= '0;
      phase_q          <= PH_HUNT;
      field_count_q    <= '0;
      payload_length_q <= '0;
      base_stopped_q   <= 1'b0;
      ext_stopped_q    <= 1'b0;
      name_out_pos_q   <= '0;
    end else if (fire_i) begin
      sync_shift_q     <= sync_shift_d;
      phase_q          <= phase_d;
      field_count_q    <= field_count_d;
      payload_length_q <= payload_length_d;
      base_stopped_q   <= base_stopped_d;
      ext_stopped_q    <= ext_stopped_d;
      name_out_pos_q   <= name_out_pos_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LEN |-> field_count_q < 32'(LEN_BYTES))
    else $error("length byte count out of range");
  a_pair_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.count == 2'd2 |-> phase_q == PH_NAME)
    else $error("two results outside the name field");
`endif

endmodule

// File: rtl/core/ffr_res_queue.sv
// Result queue: takes zero to two results per cycle, delivers one per beat.
// Depends on ffr_pkg.
module ffr_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ffr_pkg::res_grp_t grp_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ffr_pkg::res_t     head_o
);
  import ffr_pkg::*;

  res_t            mem_q [QDepth];
  logic [QAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0]  count_q;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n  = push_i ? grp_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = count_q != '0;
  assign room_o  = count_q <= QCw'(QDepth - 2);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) mem_q[wr_ptr_q] <= grp_i.r0;
    if (push_n == 2'd2) mem_q[wr_ptr_q + QAw'(1)] <= grp_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAw'(push_n);
      if (pop) rd_ptr_q <= rd_ptr_q + QAw'(1);
      count_q <= count_q + QCw'(push_n) - QCw'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 |-> count_q <= QCw'(QDepth - 2))
    else $error("result queue pushed without room");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCw'(QDepth))
    else $error("result queue count beyond depth");
`endif

endmodule

// File: rtl/core/file_frame_receiver_core.sv
// Top level of the framed file receiver: input byte register, frame parser
// and result queue. Depends on ffr_pkg, ffr_frame_ctrl and ffr_res_queue.
//
//  Channel  Dir  tdata                              tuser                  tlast
//  s_*      in   [7:0] rx_byte                      -                      -
//  m_*      out  [7:0] data, [39:8] offset          [1:0] kind,            end_of_frame
//                                                   [2] last_of_run
//
// A received byte is registered on its beat and parsed once the queue has
// room; parsing writes its zero, one or two results into a four-entry result queue.
// One byte is taken per cycle while the queue has two free entries; the
// output side delivers one result per beat, so name bytes that give two
// results cost two output beats. A result passes through the input byte
// register and the result queue. Reset (asynchronous, active low) returns
// the parser to the sync hunt with an empty queue. A stall on the output
// side fills the queue and then holds the input side off; nothing is dropped.
module file_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes: [7:0] rx_byte.
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,
  // Results.
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,  // [7:0] data, [39:8] offset
  output logic [2:0]  m_tuser_o,  // [1:0] kind, [2] last_of_run
  output logic        m_tlast_o   // end_of_frame
);
  import ffr_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       room;
  logic       fire;
  res_grp_t   grp;
  res_t       head;

  // A held byte moves on when the queue can absorb its worst case.
  assign fire       = in_valid_q && room;
  assign s_tready_o = !in_valid_q || room;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_tvalid_i && s_tready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) in_byte_q <= s_tdata_i;
  end

  ffr_frame_ctrl u_frame_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (grp)
  );

  ffr_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .grp_i   (grp),
    .room_o  (room),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .head_o  (head)
  );

  assign m_tdata_o = {head.offset, head.data};
  assign m_tuser_o = {head.last_of_run, head.kind};
  assign m_tlast_o = head.end_of_frame;

`ifndef NO_ASSERTIONS
  a_eof_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tuser_o[2])
    else $error("end of frame not on the last result of its byte");
`endif

endmodule
